@@ rtl/sls_pkg.sv @@
// shared link session arbiter: package with state codes, status codes and types
// used by sls_step, shared_link_session_fsm_top and sls_checker; no dependencies
package sls_pkg;

    localparam int unsigned LIMIT_W = 6;

    // session states
    localparam logic [1:0] ST_IDLE      = 2'd0;
    localparam logic [1:0] ST_AUTOPOLL  = 2'd1;
    localparam logic [1:0] ST_PRIMARY   = 2'd2;
    localparam logic [1:0] ST_SECONDARY = 2'd3;

    // status codes
    localparam logic [1:0] RC_OK       = 2'd0;
    localparam logic [1:0] RC_BUSY     = 2'd1;
    localparam logic [1:0] RC_ABNORMAL = 2'd2;
    localparam logic [1:0] RC_AVAIL    = 2'd3;

    // request modes
    localparam logic [2:0] MODE_AUTOPOLL  = 3'd0;
    localparam logic [2:0] MODE_START_PRI = 3'd1;
    localparam logic [2:0] MODE_START_SEC = 3'd2;
    localparam logic [2:0] MODE_END_PRI   = 3'd3;
    localparam logic [2:0] MODE_END_SEC   = 3'd4;
    localparam logic [2:0] MODE_TICK      = 3'd5;
    localparam logic [2:0] MODE_AVAIL     = 3'd6;
    localparam logic [2:0] MODE_UNUSED    = 3'd7;

    // request flag bits
    localparam int unsigned FLAG_CHECK_ACCESS = 0;
    localparam int unsigned FLAG_WAIT_ALWAYS  = 1;
    localparam int unsigned FLAG_WAIT_FIELD   = 2;

    localparam logic [1:0] SEC_FREE_BIT = 2'd2;

    localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RESET = LIMIT_W'(30);

    typedef struct packed {
        logic [1:0]         st;
        logic               pend;
        logic [LIMIT_W-1:0] left;
        logic [3:0]         mask;
        logic               sel;
        logic               pwr;
    } t_state;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] request_flags;
        logic       access_disabled;
        logic       power_on_failed;
        logic       field_detect_high;
        logic [1:0] avail_source;
        logic       avail_level;
    } t_item;

    typedef struct packed {
        logic [1:0] status_code;
        logic       select_level;
        logic       power_level;
        logic       power_wait_needed;
        logic       all_available;
        logic       wake_pulse;
        logic [1:0] session_now;
    } t_result;

endpackage

@@ rtl/sls_step.sv @@
// shared link session arbiter: transition and action table for one word
// combinational; depends on sls_pkg
module sls_step (
    input  sls_pkg::t_state                      i_cur,
    input  sls_pkg::t_item                       i_item,
    input  logic [sls_pkg::LIMIT_W-1:0]          i_retry_limit,
    output sls_pkg::t_state                      o_next,
    output sls_pkg::t_result                     o_result,
    output logic                                 o_has_result
);
    import sls_pkg::*;

    logic [2:0]         ev;
    logic               run_event;
    logic               defer;
    logic               wait_n;
    logic               wake;
    logic [1:0]         status;
    logic [LIMIT_W-1:0] eff_limit;
    t_state             n;

    assign eff_limit = (i_retry_limit == '0) ? LIMIT_W'(1) : i_retry_limit;
    // a tick replays the start-secondary row
    assign ev = (i_item.mode == MODE_TICK) ? MODE_START_SEC : i_item.mode;
    assign run_event = (i_item.mode <= MODE_END_SEC) ||
                       ((i_item.mode == MODE_TICK) && i_cur.pend);

    always_comb begin
        n            = i_cur;
        defer        = 1'b0;
        wait_n       = 1'b0;
        wake         = 1'b0;
        status       = RC_OK;
        o_has_result = 1'b0;

        if (run_event) begin
            unique case (i_cur.st)
                ST_IDLE: begin
                    if (ev == MODE_AUTOPOLL || ev == MODE_START_PRI) begin
                        if ((i_item.request_flags[FLAG_CHECK_ACCESS] && i_item.access_disabled)
                            || i_item.power_on_failed) begin
                            n.st   = ST_IDLE;
                            n.sel  = 1'b0;
                            n.pwr  = 1'b0;
                            status = RC_BUSY;
                        end else begin
                            n.st   = (ev == MODE_AUTOPOLL) ? ST_AUTOPOLL : ST_PRIMARY;
                            n.sel  = 1'b1;
                            n.pwr  = 1'b1;
                            wait_n = i_item.request_flags[FLAG_WAIT_ALWAYS] |
                                     (i_item.request_flags[FLAG_WAIT_FIELD] &
                                      i_item.field_detect_high);
                        end
                    end else if (ev == MODE_START_SEC) begin
                        n.sel               = 1'b0;
                        n.mask[SEC_FREE_BIT] = 1'b0;
                        n.st                = ST_SECONDARY;
                    end
                end
                ST_AUTOPOLL: begin
                    if (ev == MODE_START_SEC) begin
                        n.st   = ST_PRIMARY;
                        n.pend = 1'b1;
                        n.left = eff_limit;
                        defer  = 1'b1;
                    end else if (ev == MODE_END_PRI) begin
                        n.st  = ST_IDLE;
                        n.sel = 1'b0;
                        n.pwr = 1'b0;
                    end else begin
                        status = RC_ABNORMAL;
                    end
                end
                ST_PRIMARY: begin
                    if (ev == MODE_START_SEC) begin
                        status = RC_BUSY;
                    end else if (ev == MODE_END_PRI) begin
                        n.st  = ST_IDLE;
                        n.sel = 1'b0;
                        n.pwr = 1'b0;
                    end else begin
                        status = RC_ABNORMAL;
                    end
                end
                default: begin
                    if (ev == MODE_AUTOPOLL || ev == MODE_START_PRI) begin
                        status = RC_BUSY;
                    end else if (ev == MODE_END_PRI) begin
                        status = RC_ABNORMAL;
                    end else if (ev == MODE_END_SEC) begin
                        n.mask[SEC_FREE_BIT] = 1'b1;
                        wake = &n.mask;
                        n.st = ST_IDLE;
                    end
                end
            endcase

            if (defer) begin
                o_has_result = 1'b0;
            end else if (i_item.mode == MODE_TICK) begin
                // failed attempt with tries left stays silent
                if (status != RC_OK && i_cur.left > LIMIT_W'(1)) begin
                    n.left       = i_cur.left - LIMIT_W'(1);
                    o_has_result = 1'b0;
                end else begin
                    n.pend       = 1'b0;
                    n.left       = '0;
                    o_has_result = 1'b1;
                end
            end else begin
                o_has_result = 1'b1;
            end
        end else if (i_item.mode == MODE_AVAIL) begin
            n.mask[i_item.avail_source] = i_item.avail_level;
            wake         = &n.mask;
            status       = RC_AVAIL;
            o_has_result = 1'b1;
        end
    end

    assign o_next                     = n;
    assign o_result.status_code       = status;
    assign o_result.select_level      = n.sel;
    assign o_result.power_level       = n.pwr;
    assign o_result.power_wait_needed = wait_n;
    assign o_result.all_available     = &n.mask;
    assign o_result.wake_pulse        = wake;
    assign o_result.session_now       = n.st;

endmodule

@@ rtl/shared_link_session_fsm_top.sv @@
// shared link session arbiter: top level with input register, session state and
// result register; depends on sls_pkg and sls_step
//
// usage:
//   input channel  i_in_valid / o_in_ready carries one request word (mode, flags,
//   line levels, availability update). output channel o_out_valid / i_out_ready
//   carries one result word (status, select, power, wait, availability, session).
//   i_cfg_we / i_cfg_data write retry_limit at once; 0 behaves as 1.
//   a word is taken into the input register, and its result is registered
//   when it advances. words that produce no result (tick with nothing
//   to report, deferred secondary open, mode 7) leave nothing on the output.
//   throughput: one word per cycle unless the output stalls; the table lookup
//   and state update are one pass of logic between the input and result registers.
//   reset (i_rst_n low, synchronous) returns to idle, clears the availability
//   mask, select and power, drops any pending retry and sets retry_limit to 30.
//   when the receiver stalls, the result register holds; an empty input register
//   still takes one more word, then o_in_ready drops until the result is taken.
module shared_link_session_fsm_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sls_pkg::LIMIT_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_mode,
    input  logic [2:0]                    i_request_flags,
    input  logic                          i_access_disabled,
    input  logic                          i_power_on_failed,
    input  logic                          i_field_detect_high,
    input  logic [1:0]                    i_avail_source,
    input  logic                          i_avail_level,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status_code,
    output logic                          o_select_level,
    output logic                          o_power_level,
    output logic                          o_power_wait_needed,
    output logic                          o_all_available,
    output logic                          o_wake_pulse,
    output logic [1:0]                    o_session_now
);
    import sls_pkg::*;

    logic               r_in_valid;
    t_item              r_item;
    t_state             r_state;
    t_state             n_state;
    logic [LIMIT_W-1:0] r_retry_limit;
    logic               r_out_valid;
    t_result            r_out;
    t_result            n_out;
    logic               step_has_result;
    logic               advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    sls_step u_step (
        .i_cur         (r_state),
        .i_item        (r_item),
        .i_retry_limit (r_retry_limit),
        .o_next        (n_state),
        .o_result      (n_out),
        .o_has_result  (step_has_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= RETRY_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_retry_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.mode              <= i_mode;
            r_item.request_flags     <= i_request_flags;
            r_item.access_disabled   <= i_access_disabled;
            r_item.power_on_failed   <= i_power_on_failed;
            r_item.field_detect_high <= i_field_detect_high;
            r_item.avail_source      <= i_avail_source;
            r_item.avail_level       <= i_avail_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{st: ST_IDLE, pend: 1'b0, left: '0, mask: '0, sel: 1'b0, pwr: 1'b0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_has_result;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_has_result) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status_code       = r_out.status_code;
    assign o_select_level      = r_out.select_level;
    assign o_power_level       = r_out.power_level;
    assign o_power_wait_needed = r_out.power_wait_needed;
    assign o_all_available     = r_out.all_available;
    assign o_wake_pulse        = r_out.wake_pulse;
    assign o_session_now       = r_out.session_now;

endmodule

@@ rtl/sls_checker.sv @@
// shared link session arbiter: port-level checker and its bind to the top level
// depends on sls_pkg
module sls_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_status_code,
    input logic       o_select_level,
    input logic       o_power_level,
    input logic       o_power_wait_needed,
    input logic       o_all_available,
    input logic       o_wake_pulse,
    input logic [1:0] o_session_now
);
    import sls_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status_code)
            && $stable(o_session_now) && $stable(o_select_level))
        else $error("result word changed while stalled");

    // select and power are both driven exactly while a primary-type session is open
    a_link_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_select_level == o_power_level) &&
            (o_select_level == (o_session_now == ST_AUTOPOLL || o_session_now == ST_PRIMARY)))
        else $error("select/power drive does not match session");

    a_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_wake_pulse |-> o_all_available)
        else $error("wake pulse without full availability");

    a_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_power_wait_needed |-> o_status_code == RC_OK && o_power_level)
        else $error("power wait flagged without successful open");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

endmodule

bind shared_link_session_fsm_top sls_checker u_sls_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_status_code       (o_status_code),
    .o_select_level      (o_select_level),
    .o_power_level       (o_power_level),
    .o_power_wait_needed (o_power_wait_needed),
    .o_all_available     (o_all_available),
    .o_wake_pulse        (o_wake_pulse),
    .o_session_now       (o_session_now)
);
